>>> rtl/lpgu_pkg.sv
`default_nettype none
package lpgu_pkg;

  localparam int SIDE  = 64;
  localparam int SITES = SIDE * SIDE;
  localparam int IDX_W = 12;
  localparam int ROW_W = $clog2(SIDE);
  localparam int CNT_W = 13;
  localparam int CFG_W = 16;
  localparam int PAY_W = 20;
  localparam int PROB_W = 16;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] STRAT_DEF  = 2'd0;
  localparam logic [1:0] STRAT_COOP = 2'd1;
  localparam logic [1:0] STRAT_PUN  = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  localparam logic CFG_SYNERGY = 1'b0;
  localparam logic CFG_FINE    = 1'b1;

  localparam logic [CFG_W-1:0] SYNERGY_RST = 16'd16384;
  localparam logic [CFG_W-1:0] FINE_RST    = 16'd4096;

  localparam int UNIT_Q12 = 4096;

  // Division by five as a multiplication by a reciprocal, exact for sums below 2^19.
  localparam int RN_W        = 19;
  localparam int RECIP_SHIFT = 21;
  localparam logic [RN_W-1:0] RECIP5 = 19'd419431;

  localparam int TAB_LAST  = 40;
  localparam int TAB_SHIFT = 7;
  localparam int TAB_IDX_W = 6;
  localparam int SAT_LIM   = TAB_LAST << TAB_SHIFT;

  localparam logic [PROB_W:0] FERMI_TAB [0:TAB_LAST] = '{
    17'd32768, 17'd37847, 17'd42687, 17'd47094, 17'd50941, 17'd54179, 17'd56822,
    17'd58925, 17'd60565, 17'd61823, 17'd62778, 17'd63495, 17'd64030, 17'd64427,
    17'd64721, 17'd64938, 17'd65097, 17'd65215, 17'd65300, 17'd65364, 17'd65410,
    17'd65444, 17'd65468, 17'd65486, 17'd65500, 17'd65509, 17'd65517, 17'd65522,
    17'd65526, 17'd65528, 17'd65530, 17'd65532, 17'd65533, 17'd65534, 17'd65534,
    17'd65535, 17'd65535, 17'd65535, 17'd65536, 17'd65536, 17'd65536
  };

  typedef struct packed {
    logic [2:0] con;
    logic [2:0] def;
    logic [2:0] pun;
  } lpgu_group_t;

  function automatic logic [IDX_W-1:0] lpgu_nbr(input logic [IDX_W-1:0] idx,
                                                input logic [1:0] dir);
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    row = ROW_W'(idx / SIDE);
    col = ROW_W'(idx % SIDE);
    case (dir)
      DIR_UP: begin
        row = (row == '0) ? ROW_W'(SIDE - 1) : row - 1'b1;
      end
      DIR_RIGHT: begin
        col = (col == ROW_W'(SIDE - 1)) ? '0 : col + 1'b1;
      end
      DIR_DOWN: begin
        row = (row == ROW_W'(SIDE - 1)) ? '0 : row + 1'b1;
      end
      DIR_LEFT: begin
        col = (col == '0) ? ROW_W'(SIDE - 1) : col - 1'b1;
      end
      default: begin
      end
    endcase
    return IDX_W'(int'(row) * SIDE + int'(col));
  endfunction

endpackage
`default_nettype wire

>>> rtl/lpgu_ram.sv
`default_nettype none
module lpgu_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 2,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/lpgu_payoff.sv
`default_nettype none
module lpgu_payoff
  import lpgu_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic [1:0]              role_i,
  input  wire lpgu_group_t             grp_i,
  input  wire logic [CFG_W-1:0]        synergy_i,
  input  wire logic [CFG_W-1:0]        fine_i,
  output logic signed [PAY_W-1:0]      payoff_o
);

  logic [RN_W-1:0]     rn_q;
  logic [RN_W-1:0]     pen_q;
  logic                unit_q;
  logic [RN_W-1:0]     pen2_q;
  logic                unit2_q;
  logic [CFG_W-1:0]    share_q;
  logic [2:0]          ncon;
  logic [2:0]          pen_cnt;
  logic [2*RN_W-1:0]   prod;

  always_comb begin
    ncon = 3'(grp_i.con + grp_i.pun);
    case (role_i)
      STRAT_PUN: pen_cnt = grp_i.def;
      STRAT_COOP: pen_cnt = 3'd0;
      default: pen_cnt = grp_i.pun;
    endcase
    prod = (2*RN_W)'(rn_q) * (2*RN_W)'(RECIP5);
  end

  always_ff @(posedge clk_i) begin
    rn_q     <= RN_W'(RN_W'(synergy_i) * RN_W'(ncon)) + RN_W'(2);
    pen_q    <= RN_W'(RN_W'(fine_i) * RN_W'(pen_cnt));
    unit_q   <= (role_i == STRAT_COOP) || (role_i == STRAT_PUN);
    share_q  <= prod[RECIP_SHIFT +: CFG_W];
    pen2_q   <= pen_q;
    unit2_q  <= unit_q;
    payoff_o <= signed'(PAY_W'(share_q)) - signed'(unit2_q ? PAY_W'(UNIT_Q12) : PAY_W'(0))
                - signed'(PAY_W'(pen2_q));
  end

endmodule
`default_nettype wire

>>> rtl/lpgu_fermi.sv
`default_nettype none
module lpgu_fermi
  import lpgu_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic signed [PAY_W-1:0] diff_i,
  output logic [PROB_W-1:0]            prob_o
);

  localparam int STEP_W = 13;
  localparam int PROD_W = STEP_W + TAB_SHIFT + 1;

  logic [PAY_W-1:0]     mag;
  logic                 sat;
  logic [TAB_IDX_W-1:0] idx;
  logic [TAB_IDX_W-1:0] idx_nxt;
  logic [PROB_W:0]      base;
  logic [PROB_W:0]      nxt;

  logic [PROB_W:0]      base_q;
  logic [STEP_W-1:0]    step_q;
  logic [TAB_SHIFT-1:0] frac_q;
  logic                 sat_q;
  logic                 neg_q;

  logic [PROD_W-1:0]    interp;
  logic [PROB_W:0]      w;

  always_comb begin
    mag     = diff_i[PAY_W-1] ? PAY_W'(-diff_i) : PAY_W'(diff_i);
    sat     = mag >= PAY_W'(SAT_LIM);
    idx     = sat ? '0 : mag[TAB_SHIFT +: TAB_IDX_W];
    idx_nxt = idx + 1'b1;
    base    = FERMI_TAB[idx];
    nxt     = FERMI_TAB[idx_nxt];

    interp = PROD_W'(step_q) * PROD_W'(frac_q) + PROD_W'(1 << (TAB_SHIFT - 1));
    w      = base_q + (PROB_W + 1)'(interp >> TAB_SHIFT);
    if (sat_q) begin
      w = (PROB_W + 1)'(1 << PROB_W);
    end
    if (neg_q) begin
      w = (PROB_W + 1)'(1 << PROB_W) - w;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base;
    step_q <= STEP_W'(nxt - base);
    frac_q <= mag[TAB_SHIFT-1:0];
    sat_q  <= sat;
    neg_q  <= diff_i[PAY_W-1];
    prob_o <= w[PROB_W] ? '1 : w[PROB_W-1:0];
  end

endmodule
`default_nettype wire

>>> rtl/lattice_public_goods_update_unit.sv
`default_nettype none
// Spatial public goods game engine: a 64 by 64 periodic lattice of defectors,
// cooperators and punishers held in one synchronous memory, with running counts.
// A request is taken when start is high and busy is low; it carries an action,
// a site index, a strategy to write, a neighbour direction and a random draw.
// Each request yields one result, shown for exactly one cycle with done_o high.
// A read or write request moves to the state ST_ONE, which registers its result.
// An update request reads ten sites one after another through the single read
// port of the memory, then passes the two group payoffs and the switch
// probability through the registered payoff and Fermi units, and ST_DECIDE
// registers its result. Busy falls as the result is registered, so a new
// request may be taken in the cycle that shows the previous result.
// The counts on the outputs are those after the request in hand.
// Configuration writes are taken at any edge with cfg_we_i high and must only
// be issued while no request is in progress.
// After reset the memory is swept to defectors, one site a cycle, over all
// 4096 sites, during which busy stays high. The receiver cannot stall results.
module lattice_public_goods_update_unit
  import lpgu_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              action_i,
  input  wire logic [IDX_W-1:0]        site_index_i,
  input  wire logic [1:0]              site_value_i,
  input  wire logic [1:0]              direction_i,
  input  wire logic [PROB_W-1:0]       draw_i,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_idx_i,
  input  wire logic [CFG_W-1:0]        cfg_wdata_i,
  output logic                         done_o,
  output logic [1:0]                   site_state_o,
  output logic                         switched_o,
  output logic signed [PAY_W-1:0]      payoff_difference_o,
  output logic [CNT_W-1:0]             cooperators_o,
  output logic [CNT_W-1:0]             defectors_o,
  output logic [CNT_W-1:0]             punishers_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ONE,
    ST_READ,
    ST_DRAIN,
    ST_CALC,
    ST_DECIDE
  } state_e;

  localparam logic [3:0] LAST_K    = 4'd9;
  localparam logic [2:0] CALC_LAST = 3'd5;

  function automatic lpgu_group_t grp_add(input lpgu_group_t g, input logic [1:0] v);
    lpgu_group_t r;
    r = g;
    case (v)
      STRAT_DEF: r.def = g.def + 1'b1;
      STRAT_PUN: r.pun = g.pun + 1'b1;
      default: r.con = g.con + 1'b1;
    endcase
    return r;
  endfunction

  state_e state_q, state_d;
  logic [3:0]       k_q, k_d;
  logic [2:0]       calc_q, calc_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [CFG_W-1:0] syn_q, syn_d;
  logic [CFG_W-1:0] fine_q, fine_d;
  logic [CNT_W-1:0] coop_q, coop_d;
  logic [CNT_W-1:0] defc_q, defc_d;
  logic [CNT_W-1:0] pun_q, pun_d;
  logic             done_q, done_d;
  logic [1:0]       sstate_q, sstate_d;
  logic             sw_q, sw_d;
  logic signed [PAY_W-1:0] dout_q, dout_d;

  logic [IDX_W-1:0]  site_q, site_d;
  logic [IDX_W-1:0]  n_q, n_d;
  logic [1:0]        action_q, action_d;
  logic [1:0]        value_q, value_d;
  logic [PROB_W-1:0] draw_q, draw_d;
  logic [1:0]        me_q, me_d;
  logic [1:0]        other_q, other_d;
  lpgu_group_t       grp_s_q, grp_s_d;
  lpgu_group_t       grp_n_q, grp_n_d;
  logic signed [PAY_W-1:0] diff_q, diff_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [1:0]       ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [1:0]       ram_rdata;

  logic signed [PAY_W-1:0] pay_s;
  logic signed [PAY_W-1:0] pay_n;
  logic signed [PAY_W:0]   diff_full;
  logic [PROB_W-1:0]       prob;
  logic [PROB_W-1:0]       prob_eff;

  logic       cnt_chg;
  logic [1:0] cnt_old;
  logic [1:0] cnt_new;
  logic [3:0] kd;
  logic       in_s;
  logic       pair;
  logic       differ;
  logic       do_sw;

  lpgu_ram #(
    .DEPTH (SITES),
    .WIDTH (2),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  lpgu_payoff u_pay_site (
    .clk_i    (clk_i),
    .role_i   (me_q),
    .grp_i    (grp_s_q),
    .synergy_i(syn_q),
    .fine_i   (fine_q),
    .payoff_o (pay_s)
  );

  lpgu_payoff u_pay_nbr (
    .clk_i    (clk_i),
    .role_i   (other_q),
    .grp_i    (grp_n_q),
    .synergy_i(syn_q),
    .fine_i   (fine_q),
    .payoff_o (pay_n)
  );

  lpgu_fermi u_fermi (
    .clk_i (clk_i),
    .diff_i(diff_q),
    .prob_o(prob)
  );

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    calc_d   = calc_q;
    clr_d    = clr_q;
    syn_d    = syn_q;
    fine_d   = fine_q;
    done_d   = 1'b0;
    sstate_d = sstate_q;
    sw_d     = sw_q;
    dout_d   = dout_q;
    site_d   = site_q;
    n_d      = n_q;
    action_d = action_q;
    value_d  = value_q;
    draw_d   = draw_q;
    me_d     = me_q;
    other_d  = other_q;
    grp_s_d  = grp_s_q;
    grp_n_d  = grp_n_q;

    ram_we    = 1'b0;
    ram_waddr = site_q;
    ram_wdata = other_q;
    ram_raddr = site_index_i;

    cnt_chg = 1'b0;
    cnt_old = me_q;
    cnt_new = other_q;

    kd   = k_q - 1'b1;
    in_s = kd inside {4'd0, [4'd2:4'd5]};

    diff_full = (PAY_W + 1)'(pay_n) - (PAY_W + 1)'(pay_s);
    if (diff_full[PAY_W] != diff_full[PAY_W-1]) begin
      diff_d = diff_full[PAY_W] ? {1'b1, {(PAY_W-1){1'b0}}} : {1'b0, {(PAY_W-1){1'b1}}};
    end else begin
      diff_d = diff_full[PAY_W-1:0];
    end

    pair = ((me_q == STRAT_COOP) && (other_q == STRAT_PUN)) ||
           ((me_q == STRAT_PUN) && (other_q == STRAT_COOP));
    differ   = me_q != other_q;
    prob_eff = pair ? '0 : prob;
    do_sw    = differ && (draw_q < prob_eff);

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNERGY: syn_d = cfg_wdata_i;
        CFG_FINE: fine_d = cfg_wdata_i;
        default: begin
        end
      endcase
    end

    if ((state_q == ST_READ) || (state_q == ST_DRAIN)) begin
      if (kd == 4'd0) begin
        me_d = ram_rdata;
      end
      if (kd == 4'd1) begin
        other_d = ram_rdata;
      end
      if (in_s) begin
        grp_s_d = grp_add(grp_s_q, ram_rdata);
      end else begin
        grp_n_d = grp_add(grp_n_q, ram_rdata);
      end
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = STRAT_DEF;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IDX_W'(SITES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          site_d   = site_index_i;
          n_d      = lpgu_nbr(site_index_i, direction_i);
          action_d = action_i;
          value_d  = site_value_i;
          draw_d   = draw_i;
          grp_s_d  = '0;
          grp_n_d  = '0;
          k_d      = 4'd1;
          if ((IDX_W + 1)'(site_index_i) >= (IDX_W + 1)'(SITES)) begin
            done_d   = 1'b1;
            sstate_d = STRAT_DEF;
            sw_d     = 1'b0;
            dout_d   = '0;
          end else if (action_i == ACT_UPDATE) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_ONE;
          end
        end
      end
      ST_ONE: begin
        sw_d     = 1'b0;
        dout_d   = '0;
        sstate_d = ram_rdata;
        if ((action_q == ACT_WRITE) && (value_q <= STRAT_PUN)) begin
          ram_we    = 1'b1;
          ram_wdata = value_q;
          cnt_chg   = 1'b1;
          cnt_old   = ram_rdata;
          cnt_new   = value_q;
          sstate_d  = value_q;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_READ: begin
        if (k_q == 4'd1) begin
          ram_raddr = n_q;
        end else if (k_q <= 4'd5) begin
          ram_raddr = lpgu_nbr(site_q, 2'(k_q - 4'd2));
        end else begin
          ram_raddr = lpgu_nbr(n_q, 2'(k_q - 4'd2));
        end
        k_d = k_q + 1'b1;
        if (k_q == LAST_K) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        calc_d  = '0;
        state_d = ST_CALC;
      end
      ST_CALC: begin
        calc_d = calc_q + 1'b1;
        if (calc_q == CALC_LAST) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        sw_d     = do_sw;
        dout_d   = differ ? diff_q : '0;
        sstate_d = do_sw ? other_q : me_q;
        if (do_sw) begin
          ram_we  = 1'b1;
          cnt_chg = 1'b1;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    coop_d = coop_q;
    defc_d = defc_q;
    pun_d  = pun_q;
    if (cnt_chg) begin
      coop_d = coop_q - CNT_W'(cnt_old == STRAT_COOP) + CNT_W'(cnt_new == STRAT_COOP);
      defc_d = defc_q - CNT_W'(cnt_old == STRAT_DEF) + CNT_W'(cnt_new == STRAT_DEF);
      pun_d  = pun_q - CNT_W'(cnt_old == STRAT_PUN) + CNT_W'(cnt_new == STRAT_PUN);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      k_q      <= '0;
      calc_q   <= '0;
      clr_q    <= '0;
      syn_q    <= SYNERGY_RST;
      fine_q   <= FINE_RST;
      coop_q   <= '0;
      defc_q   <= CNT_W'(SITES);
      pun_q    <= '0;
      done_q   <= 1'b0;
      sstate_q <= '0;
      sw_q     <= 1'b0;
      dout_q   <= '0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      calc_q   <= calc_d;
      clr_q    <= clr_d;
      syn_q    <= syn_d;
      fine_q   <= fine_d;
      coop_q   <= coop_d;
      defc_q   <= defc_d;
      pun_q    <= pun_d;
      done_q   <= done_d;
      sstate_q <= sstate_d;
      sw_q     <= sw_d;
      dout_q   <= dout_d;
    end
  end

  always_ff @(posedge clk_i) begin
    site_q   <= site_d;
    n_q      <= n_d;
    action_q <= action_d;
    value_q  <= value_d;
    draw_q   <= draw_d;
    me_q     <= me_d;
    other_q  <= other_d;
    grp_s_q  <= grp_s_d;
    grp_n_q  <= grp_n_d;
    diff_q   <= diff_d;
  end

  assign busy                = state_q != ST_IDLE;
  assign done_o              = done_q;
  assign site_state_o        = sstate_q;
  assign switched_o          = sw_q;
  assign payoff_difference_o = dout_q;
  assign cooperators_o       = coop_q;
  assign defectors_o         = defc_q;
  assign punishers_o         = pun_q;

endmodule
`default_nettype wire
